// ===== hw/rtl/ila_pkg.sv =====
// Shared types and constants for the implicit list allocator.
// Used by the datapath, the controller and the top level; no dependencies.
package ila_pkg;

  localparam int HEAP_WORDS_DEF = 16384;
  localparam int FIRST_CHUNK    = 4096;
  localparam int EXT_W          = 17;
  localparam logic [EXT_W-1:0] EXTEND_RESET = 17'd4096;
  localparam logic [31:0] SIZE_MASK = 32'hFFFF_FFF8;
  localparam logic [31:0] ALLOC_BIT = 32'h0000_0001;
  localparam logic [31:0] WORD      = 32'd4;
  localparam logic [31:0] DWORD     = 32'd8;
  localparam logic [31:0] MIN_BLOCK = 32'd16;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef enum logic [1:0] {
    MEM_IDLE,
    MEM_READ,
    MEM_WRITE,
    MEM_CLEAR
  } mem_op_t;

  typedef enum logic [2:0] {
    AS_BP_M4,
    AS_BP_M8,
    AS_PREV_M4,
    AS_NEXT_M4,
    AS_PREV_PS_M8
  } asel_t;

  typedef enum logic [4:0] {
    ACT_NONE,
    ACT_START,
    ACT_CAP_TAG,
    ACT_PLAN_FREE,
    ACT_WALK_NEXT,
    ACT_PLAN_GROW,
    ACT_PLAN_PUT,
    ACT_CAP_BSIZE,
    ACT_CAP_PREV,
    ACT_CAP_PSIZE,
    ACT_CAP_NEXT,
    ACT_CAP_PALLOC,
    ACT_PLAN_MERGE,
    ACT_GROW_RET,
    ACT_RES_BP,
    ACT_RES_MRET,
    ACT_RES_ZERO,
    ACT_RES_FULL
  } act_t;

  typedef struct packed {
    mem_op_t    op;
    asel_t      asel;
    logic [1:0] wslot;
    act_t       act;
    logic       out_load;
  } ila_cmd_t;

  typedef struct packed {
    logic       clear_done;
    logic       is_free;
    logic       req_zero;
    logic       sz_zero;
    logic       fit;
    logic       walk_end;
    logic       grow_fail;
    logic       mret_zero;
    logic [2:0] nw;
  } ila_status_t;

endpackage

// ===== hw/rtl/ila_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
module ila_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== hw/rtl/ila_datapath.sv =====
// Allocator datapath: tag RAM, address arithmetic, working registers,
// write plan slots and result register. Depends on ila_pkg and ila_ram.
module ila_datapath #(
  parameter int HEAP_WORDS = ila_pkg::HEAP_WORDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ila_pkg::ila_cmd_t             cmd,
  output ila_pkg::ila_status_t          st,
  input  logic                          in_free,
  input  logic [15:0]                   in_req,
  input  logic [15:0]                   in_addr,
  input  logic                          cfg_we,
  input  logic [ila_pkg::EXT_W-1:0]     cfg_wdata,
  output logic [15:0]                   payload_addr,
  output logic [1:0]                    status
);

  localparam int HEAP_BYTES = (HEAP_WORDS * 4 < 65536) ? HEAP_WORDS * 4 : 65536;
  localparam int RAM_WORDS  = HEAP_BYTES / 4;
  localparam int IDX_W      = $clog2(RAM_WORDS);
  localparam int CHUNK      = (ila_pkg::FIRST_CHUNK > HEAP_BYTES - 16) ?
                              ((HEAP_BYTES - 16) & ~7) : ila_pkg::FIRST_CHUNK;
  localparam logic [31:0]      HEAP_LIM  = 32'(HEAP_BYTES);
  localparam logic [31:0]      CHUNK_V   = 32'(CHUNK);
  localparam logic [16:0]      BRK_RESET = 17'(16 + CHUNK);
  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(RAM_WORDS - 1);
  localparam logic [IDX_W-1:0] IDX_FTR   = IDX_W'((8 + CHUNK) / 4);
  localparam logic [IDX_W-1:0] IDX_EPI   = IDX_W'((12 + CHUNK) / 4);

  logic [31:0] bp, bsize, prev, psize, nxt, nsize, tag, mret;
  logic [16:0] asize;
  logic        palloc, nalloc, is_free, req_zero;
  logic [16:0] brk;
  logic [ila_pkg::EXT_W-1:0] ext;
  logic [31:0] wa [4];
  logic [31:0] wd [4];
  logic [2:0]  nw;
  logic [15:0] res;
  logic [1:0]  stat;
  logic [IDX_W-1:0] clr;
  logic        rd_ok;

  logic [31:0] ram_q, rdat, rsz, tsz, raddr, maddr, init_val, ram_wdata;
  logic        inr, ram_we;
  logic [IDX_W-1:0] ram_addr;
  logic [31:0] asize32, gsize, diff;
  logic [16:0] gmax;
  logic [14:0] gwords;
  logic [15:0] gwords_r;

  assign rdat    = rd_ok ? ram_q : 32'd0;
  assign rsz     = rdat & ila_pkg::SIZE_MASK;
  assign tsz     = tag & ila_pkg::SIZE_MASK;
  assign asize32 = 32'(asize);
  assign diff    = tsz - asize32;

  assign gmax     = (asize > ext) ? asize : ext;
  assign gwords   = gmax[16:2];
  assign gwords_r = 16'(gwords) + 16'(gwords[0]);
  assign gsize    = 32'({gwords_r, 2'b00});

  always_comb begin
    case (cmd.asel)
      ila_pkg::AS_BP_M4:      raddr = bp - ila_pkg::WORD;
      ila_pkg::AS_BP_M8:      raddr = bp - ila_pkg::DWORD;
      ila_pkg::AS_PREV_M4:    raddr = prev - ila_pkg::WORD;
      ila_pkg::AS_NEXT_M4:    raddr = nxt - ila_pkg::WORD;
      ila_pkg::AS_PREV_PS_M8: raddr = prev + psize - ila_pkg::DWORD;
      default:                raddr = bp - ila_pkg::WORD;
    endcase
  end

  always_comb begin
    if (clr == IDX_W'(1) || clr == IDX_W'(2)) begin
      init_val = ila_pkg::DWORD | ila_pkg::ALLOC_BIT;
    end else if (clr == IDX_W'(3) || clr == IDX_FTR) begin
      init_val = CHUNK_V;
    end else if (clr == IDX_EPI) begin
      init_val = ila_pkg::ALLOC_BIT;
    end else begin
      init_val = 32'd0;
    end
  end

  assign maddr = (cmd.op == ila_pkg::MEM_WRITE) ? wa[cmd.wslot] : raddr;
  assign inr   = maddr[31:2] < 30'(RAM_WORDS);

  always_comb begin
    if (cmd.op == ila_pkg::MEM_CLEAR) begin
      ram_we    = 1'b1;
      ram_addr  = clr;
      ram_wdata = init_val;
    end else begin
      ram_we    = (cmd.op == ila_pkg::MEM_WRITE) && inr;
      ram_addr  = maddr[IDX_W+1:2];
      ram_wdata = wd[cmd.wslot];
    end
  end

  ila_ram #(
    .WIDTH (32),
    .DEPTH (RAM_WORDS)
  ) u_tags (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_q)
  );

  always_comb begin
    st.clear_done = (clr == IDX_LAST);
    st.is_free    = is_free;
    st.req_zero   = req_zero;
    st.sz_zero    = (tsz == 32'd0);
    st.fit        = !tag[0] && (asize32 <= tsz);
    st.walk_end   = tsz >= (HEAP_LIM - bp);
    st.grow_fail  = (32'(brk) > HEAP_LIM) || (gsize > HEAP_LIM - 32'(brk));
    st.mret_zero  = (mret == 32'd0);
    st.nw         = nw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr <= '0;
      brk <= BRK_RESET;
      ext <= ila_pkg::EXTEND_RESET;
    end else begin
      if (cmd.op == ila_pkg::MEM_CLEAR && clr != IDX_LAST) begin
        clr <= clr + IDX_W'(1);
      end
      if (cfg_we) begin
        ext <= cfg_wdata;
      end
      if (cmd.act == ila_pkg::ACT_PLAN_GROW) begin
        brk <= 17'(32'(brk) + gsize);
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_ok <= inr;
    if (cmd.out_load) begin
      payload_addr <= res;
      status       <= stat;
    end
    case (cmd.act)
      ila_pkg::ACT_START: begin
        is_free  <= in_free;
        req_zero <= (in_req == 16'd0);
        bp       <= in_free ? 32'(in_addr) : ila_pkg::DWORD;
        asize    <= (in_req <= 16'd8) ? 17'd16 : ((17'(in_req) + 17'd15) & 17'h1FFF8);
      end
      ila_pkg::ACT_CAP_TAG:    tag <= rdat;
      ila_pkg::ACT_PLAN_FREE: begin
        wa[0] <= bp - ila_pkg::WORD;
        wd[0] <= tsz;
        wa[1] <= bp + tsz - ila_pkg::DWORD;
        wd[1] <= tsz;
        nw    <= 3'd2;
      end
      ila_pkg::ACT_WALK_NEXT:  bp <= bp + tsz;
      ila_pkg::ACT_PLAN_GROW: begin
        wa[0] <= 32'(brk) - ila_pkg::WORD;
        wd[0] <= gsize;
        wa[1] <= 32'(brk) + gsize - ila_pkg::DWORD;
        wd[1] <= gsize;
        wa[2] <= 32'(brk) + gsize - ila_pkg::WORD;
        wd[2] <= ila_pkg::ALLOC_BIT;
        nw    <= 3'd3;
        bp    <= 32'(brk);
      end
      ila_pkg::ACT_PLAN_PUT: begin
        wa[0] <= bp - ila_pkg::WORD;
        if (diff >= ila_pkg::MIN_BLOCK) begin
          wd[0] <= asize32 | ila_pkg::ALLOC_BIT;
          wa[1] <= bp + asize32 - ila_pkg::DWORD;
          wd[1] <= asize32 | ila_pkg::ALLOC_BIT;
          wa[2] <= bp + asize32 - ila_pkg::WORD;
          wd[2] <= diff;
          wa[3] <= bp + tsz - ila_pkg::DWORD;
          wd[3] <= diff;
          nw    <= 3'd4;
        end else begin
          wd[0] <= tsz | ila_pkg::ALLOC_BIT;
          wa[1] <= bp + tsz - ila_pkg::DWORD;
          wd[1] <= tsz | ila_pkg::ALLOC_BIT;
          nw    <= 3'd2;
        end
      end
      ila_pkg::ACT_CAP_BSIZE: begin
        bsize <= rsz;
        nxt   <= bp + rsz;
      end
      ila_pkg::ACT_CAP_PREV:   prev <= bp - rsz;
      ila_pkg::ACT_CAP_PSIZE:  psize <= rsz;
      ila_pkg::ACT_CAP_NEXT: begin
        nsize  <= rsz;
        nalloc <= rdat[0];
      end
      ila_pkg::ACT_CAP_PALLOC: palloc <= rdat[0];
      ila_pkg::ACT_PLAN_MERGE: begin
        if (palloc && nalloc) begin
          nw   <= 3'd0;
          mret <= bp;
        end else if (palloc) begin
          wa[0] <= nxt + nsize - ila_pkg::DWORD;
          wd[0] <= bsize + nsize;
          wa[1] <= bp - ila_pkg::WORD;
          wd[1] <= bsize + nsize;
          nw    <= 3'd2;
          mret  <= bp;
        end else if (nalloc) begin
          wa[0] <= nxt - ila_pkg::DWORD;
          wd[0] <= bsize + psize;
          wa[1] <= prev - ila_pkg::WORD;
          wd[1] <= bsize + psize;
          nw    <= 3'd2;
          mret  <= prev;
        end else begin
          wa[0] <= nxt + nsize - ila_pkg::DWORD;
          wd[0] <= bsize + psize + nsize;
          wa[1] <= prev - ila_pkg::WORD;
          wd[1] <= bsize + psize + nsize;
          nw    <= 3'd2;
          mret  <= prev;
        end
      end
      ila_pkg::ACT_GROW_RET:   bp <= mret;
      ila_pkg::ACT_RES_BP: begin
        res  <= bp[15:0];
        stat <= ila_pkg::ST_OK;
      end
      ila_pkg::ACT_RES_MRET: begin
        res  <= mret[15:0];
        stat <= ila_pkg::ST_OK;
      end
      ila_pkg::ACT_RES_ZERO: begin
        res  <= 16'd0;
        stat <= ila_pkg::ST_ZERO;
      end
      ila_pkg::ACT_RES_FULL: begin
        res  <= 16'd0;
        stat <= ila_pkg::ST_FULL;
      end
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/ila_ctrl.sv =====
// Allocator controller: sequences tag reads, list walk, growth, merge and
// write plans, and owns the stream handshakes. Depends on ila_pkg.
module ila_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  ila_pkg::ila_status_t  st,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output ila_pkg::ila_cmd_t     cmd
);

  typedef enum logic [30:0] {
    S_CLEAR    = 31'h0000_0001,
    S_IDLE     = 31'h0000_0002,
    S_DISPATCH = 31'h0000_0004,
    S_FR_RD    = 31'h0000_0008,
    S_FR_CAP   = 31'h0000_0010,
    S_FR_PLAN  = 31'h0000_0020,
    S_WALK_RD  = 31'h0000_0040,
    S_WALK_CAP = 31'h0000_0080,
    S_WALK_CHK = 31'h0000_0100,
    S_GROW_CHK = 31'h0000_0200,
    S_GROW_RET = 31'h0000_0400,
    S_PUT_RD   = 31'h0000_0800,
    S_PUT_CAP  = 31'h0000_1000,
    S_PUT_PLAN = 31'h0000_2000,
    S_MG_RD0   = 31'h0000_4000,
    S_MG_CAP0  = 31'h0000_8000,
    S_MG_RD1   = 31'h0001_0000,
    S_MG_CAP1  = 31'h0002_0000,
    S_MG_RD2   = 31'h0004_0000,
    S_MG_CAP2  = 31'h0008_0000,
    S_MG_RD3   = 31'h0010_0000,
    S_MG_CAP3  = 31'h0020_0000,
    S_MG_RD4   = 31'h0040_0000,
    S_MG_CAP4  = 31'h0080_0000,
    S_MG_PLAN  = 31'h0100_0000,
    S_WRITE    = 31'h0200_0000,
    S_RES_ZERO = 31'h0400_0000,
    S_RES_FULL = 31'h0800_0000,
    S_RES_BP   = 31'h1000_0000,
    S_RES_MRET = 31'h2000_0000,
    S_DONE     = 31'h4000_0000
  } state_t;

  state_t     state, state_next, wr_ret, wr_ret_next;
  logic [2:0] wcnt, wcnt_next;
  logic       out_free;

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      wr_ret   <= S_IDLE;
      wcnt     <= 3'd0;
      m_tvalid <= 1'b0;
    end else begin
      state  <= state_next;
      wr_ret <= wr_ret_next;
      wcnt   <= wcnt_next;
      if (state == S_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next   = state;
    wr_ret_next  = wr_ret;
    wcnt_next    = wcnt;
    cmd.op       = ila_pkg::MEM_IDLE;
    cmd.asel     = ila_pkg::AS_BP_M4;
    cmd.wslot    = wcnt[1:0];
    cmd.act      = ila_pkg::ACT_NONE;
    cmd.out_load = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.op = ila_pkg::MEM_CLEAR;
        if (st.clear_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.act    = ila_pkg::ACT_START;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (st.is_free) begin
          state_next = S_FR_RD;
        end else if (st.req_zero) begin
          state_next = S_RES_ZERO;
        end else begin
          state_next = S_WALK_RD;
        end
      end
      S_FR_RD: begin
        cmd.op     = ila_pkg::MEM_READ;
        state_next = S_FR_CAP;
      end
      S_FR_CAP: begin
        cmd.act    = ila_pkg::ACT_CAP_TAG;
        state_next = S_FR_PLAN;
      end
      S_FR_PLAN: begin
        cmd.act     = ila_pkg::ACT_PLAN_FREE;
        wr_ret_next = S_MG_RD0;
        state_next  = S_WRITE;
      end
      S_WALK_RD: begin
        cmd.op     = ila_pkg::MEM_READ;
        state_next = S_WALK_CAP;
      end
      S_WALK_CAP: begin
        cmd.act    = ila_pkg::ACT_CAP_TAG;
        state_next = S_WALK_CHK;
      end
      S_WALK_CHK: begin
        if (st.sz_zero) begin
          state_next = S_GROW_CHK;
        end else if (st.fit) begin
          state_next = S_PUT_RD;
        end else if (st.walk_end) begin
          state_next = S_GROW_CHK;
        end else begin
          cmd.act    = ila_pkg::ACT_WALK_NEXT;
          state_next = S_WALK_RD;
        end
      end
      S_GROW_CHK: begin
        if (st.grow_fail) begin
          state_next = S_RES_FULL;
        end else begin
          cmd.act     = ila_pkg::ACT_PLAN_GROW;
          wr_ret_next = S_MG_RD0;
          state_next  = S_WRITE;
        end
      end
      S_GROW_RET: begin
        if (st.mret_zero) begin
          state_next = S_RES_FULL;
        end else begin
          cmd.act    = ila_pkg::ACT_GROW_RET;
          state_next = S_PUT_RD;
        end
      end
      S_PUT_RD: begin
        cmd.op     = ila_pkg::MEM_READ;
        state_next = S_PUT_CAP;
      end
      S_PUT_CAP: begin
        cmd.act    = ila_pkg::ACT_CAP_TAG;
        state_next = S_PUT_PLAN;
      end
      S_PUT_PLAN: begin
        cmd.act     = ila_pkg::ACT_PLAN_PUT;
        wr_ret_next = S_RES_BP;
        state_next  = S_WRITE;
      end
      S_MG_RD0: begin
        cmd.op     = ila_pkg::MEM_READ;
        state_next = S_MG_CAP0;
      end
      S_MG_CAP0: begin
        cmd.act    = ila_pkg::ACT_CAP_BSIZE;
        state_next = S_MG_RD1;
      end
      S_MG_RD1: begin
        cmd.op     = ila_pkg::MEM_READ;
        cmd.asel   = ila_pkg::AS_BP_M8;
        state_next = S_MG_CAP1;
      end
      S_MG_CAP1: begin
        cmd.act    = ila_pkg::ACT_CAP_PREV;
        state_next = S_MG_RD2;
      end
      S_MG_RD2: begin
        cmd.op     = ila_pkg::MEM_READ;
        cmd.asel   = ila_pkg::AS_PREV_M4;
        state_next = S_MG_CAP2;
      end
      S_MG_CAP2: begin
        cmd.act    = ila_pkg::ACT_CAP_PSIZE;
        state_next = S_MG_RD3;
      end
      S_MG_RD3: begin
        cmd.op     = ila_pkg::MEM_READ;
        cmd.asel   = ila_pkg::AS_NEXT_M4;
        state_next = S_MG_CAP3;
      end
      S_MG_CAP3: begin
        cmd.act    = ila_pkg::ACT_CAP_NEXT;
        state_next = S_MG_RD4;
      end
      S_MG_RD4: begin
        cmd.op     = ila_pkg::MEM_READ;
        cmd.asel   = ila_pkg::AS_PREV_PS_M8;
        state_next = S_MG_CAP4;
      end
      S_MG_CAP4: begin
        cmd.act    = ila_pkg::ACT_CAP_PALLOC;
        state_next = S_MG_PLAN;
      end
      S_MG_PLAN: begin
        cmd.act     = ila_pkg::ACT_PLAN_MERGE;
        wr_ret_next = st.is_free ? S_RES_MRET : S_GROW_RET;
        state_next  = S_WRITE;
      end
      S_WRITE: begin
        if (wcnt == st.nw) begin
          wcnt_next  = 3'd0;
          state_next = wr_ret;
        end else begin
          cmd.op    = ila_pkg::MEM_WRITE;
          wcnt_next = wcnt + 3'd1;
        end
      end
      S_RES_ZERO: begin
        cmd.act    = ila_pkg::ACT_RES_ZERO;
        state_next = S_DONE;
      end
      S_RES_FULL: begin
        cmd.act    = ila_pkg::ACT_RES_FULL;
        state_next = S_DONE;
      end
      S_RES_BP: begin
        cmd.act    = ila_pkg::ACT_RES_BP;
        state_next = S_DONE;
      end
      S_RES_MRET: begin
        cmd.act    = ila_pkg::ACT_RES_MRET;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/implicit_list_allocator.sv =====
// Free merges the freed block with any free neighbours; allocate walks the block headers
// first fit, places (and, with room left, splits) the chosen block, and grows the heap when none fits.
// One transaction at a time: the controller takes a new one only in its idle state.
// Reset: a clearing pass writes the initial heap image over all HEAP_BYTES/4 tag words
// (16384 by default) before the first transaction is taken.
module implicit_list_allocator #(
  parameter int HEAP_WORDS = ila_pkg::HEAP_WORDS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic                      s_tuser,    // cmd
  input  logic [31:0]               s_tdata,    // request_size, block_addr
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [23:0]               m_tdata,    // payload_addr, status, zero pad
  input  logic                      cfg_we,
  input  logic [ila_pkg::EXT_W-1:0] cfg_wdata
);

  ila_pkg::ila_cmd_t    cmd;
  ila_pkg::ila_status_t st;
  logic [15:0]          payload_addr;
  logic [1:0]           status;

  ila_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .st       (st),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  ila_datapath #(
    .HEAP_WORDS (HEAP_WORDS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .in_free      (s_tuser),
    .in_req       (s_tdata[15:0]),
    .in_addr      (s_tdata[31:16]),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .payload_addr (payload_addr),
    .status       (status)
  );

  assign m_tdata = {6'd0, status, payload_addr};

endmodule

// ===== hw/rtl/ila_checker.sv =====
// Port-level checks for the allocator, bound to the top level.
// Depends on the top level's ports and ila_pkg.
module ila_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[17:16] <= ila_pkg::ST_FULL)
    else $error("status code out of range");

  a_fail_addr_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[17:16] != ila_pkg::ST_OK) |-> m_tdata[15:0] == 16'd0)
    else $error("failed transaction carries an address");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second transaction taken while busy");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result changed while stalled");

endmodule

bind implicit_list_allocator ila_checker u_ila_checker (.*);

// ===== tb/sv/ila_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for implicit_list_allocator: a heap tag-store model, expected-result queue.
// Watches the input, result and config channels; depends on ila_pkg.
module ila_scoreboard (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  input  logic                      s_tready,
  input  logic                      s_tuser,
  input  logic [31:0]               s_tdata,
  input  logic                      m_tvalid,
  input  logic                      m_tready,
  input  logic [23:0]               m_tdata,
  input  logic                      cfg_we,
  input  logic [ila_pkg::EXT_W-1:0] cfg_wdata,
  output int                        fails,
  output int                        pending
);

  localparam int HEAP_BYTES = 65536;
  localparam int NWORDS     = HEAP_BYTES / 4;

  typedef struct packed {
    logic [15:0] addr;
    logic [1:0]  status;
  } alloc_result_t;

  logic [31:0]               tags [NWORDS];
  logic [31:0]               brk;
  logic [ila_pkg::EXT_W-1:0] grow_min;
  alloc_result_t             results_due [$];

  function automatic logic [31:0] tag_rd(logic [31:0] a);
    logic [31:0] w;
    w = a >> 2;
    return (w < NWORDS) ? tags[w] : 32'd0;
  endfunction

  function automatic void tag_wr(logic [31:0] a, logic [31:0] v);
    logic [31:0] w;
    w = a >> 2;
    if (w < NWORDS) tags[w] = v;
  endfunction

  function automatic logic [31:0] coalesce(logic [31:0] bp);
    logic [31:0] bsize, prev, psize, nxt, nsize, total;
    logic palloc, nalloc;
    bsize  = tag_rd(bp - ila_pkg::WORD) & ila_pkg::SIZE_MASK;
    prev   = bp - (tag_rd(bp - ila_pkg::DWORD) & ila_pkg::SIZE_MASK);
    psize  = tag_rd(prev - ila_pkg::WORD) & ila_pkg::SIZE_MASK;
    nxt    = bp + bsize;
    nsize  = tag_rd(nxt - ila_pkg::WORD) & ila_pkg::SIZE_MASK;
    palloc = (tag_rd(prev + psize - ila_pkg::DWORD) & ila_pkg::ALLOC_BIT) != 0;
    nalloc = (tag_rd(nxt - ila_pkg::WORD) & ila_pkg::ALLOC_BIT) != 0;
    if (palloc && nalloc) return bp;
    if (palloc) begin
      total = bsize + nsize;
      tag_wr(nxt + nsize - ila_pkg::DWORD, total);
      tag_wr(bp - ila_pkg::WORD, total);
      return bp;
    end
    if (nalloc) begin
      total = bsize + psize;
      tag_wr(bp + bsize - ila_pkg::DWORD, total);
      tag_wr(prev - ila_pkg::WORD, total);
      return prev;
    end
    total = bsize + psize + nsize;
    tag_wr(nxt + nsize - ila_pkg::DWORD, total);
    tag_wr(prev - ila_pkg::WORD, total);
    return prev;
  endfunction

  function automatic logic [31:0] raise_break(logic [31:0] size);
    logic [31:0] bp;
    if (brk > HEAP_BYTES || size > HEAP_BYTES - brk) return 32'd0;
    bp = brk;
    tag_wr(bp - ila_pkg::WORD, size);
    tag_wr(bp + size - ila_pkg::DWORD, size);
    tag_wr(bp + size - ila_pkg::WORD, ila_pkg::ALLOC_BIT);
    brk = bp + size;
    return coalesce(bp);
  endfunction

  function automatic logic [31:0] scan_first(logic [31:0] asize);
    logic [31:0] bp, t, sz;
    bp = ila_pkg::DWORD;
    forever begin
      t  = tag_rd(bp - ila_pkg::WORD);
      sz = t & ila_pkg::SIZE_MASK;
      if (sz == 0) return 32'd0;
      if ((t & ila_pkg::ALLOC_BIT) == 0 && asize <= sz) return bp;
      if (sz >= HEAP_BYTES - bp) return 32'd0;
      bp = bp + sz;
    end
  endfunction

  function automatic void place(logic [31:0] bp, logic [31:0] asize);
    logic [31:0] csize, rest, nb;
    csize = tag_rd(bp - ila_pkg::WORD) & ila_pkg::SIZE_MASK;
    if (csize - asize >= ila_pkg::MIN_BLOCK) begin
      rest = csize - asize;
      nb   = bp + asize;
      tag_wr(bp - ila_pkg::WORD, asize | ila_pkg::ALLOC_BIT);
      tag_wr(bp + asize - ila_pkg::DWORD, asize | ila_pkg::ALLOC_BIT);
      tag_wr(nb - ila_pkg::WORD, rest);
      tag_wr(nb + rest - ila_pkg::DWORD, rest);
    end else begin
      tag_wr(bp - ila_pkg::WORD, csize | ila_pkg::ALLOC_BIT);
      tag_wr(bp + csize - ila_pkg::DWORD, csize | ila_pkg::ALLOC_BIT);
    end
  endfunction

  function automatic alloc_result_t predict(logic op, logic [15:0] req, logic [15:0] ba);
    alloc_result_t r;
    logic [31:0] sz, asize, bp, e, words, a;
    r = '{addr: 16'd0, status: ila_pkg::ST_OK};
    a = {16'd0, ba};
    if (op) begin
      sz = tag_rd(a - ila_pkg::WORD) & ila_pkg::SIZE_MASK;
      tag_wr(a - ila_pkg::WORD, sz);
      tag_wr(a + sz - ila_pkg::DWORD, sz);
      r.addr = coalesce(a);
    end else if (req == 0) begin
      r.status = ila_pkg::ST_ZERO;
    end else begin
      asize = (req <= ila_pkg::DWORD) ? ila_pkg::MIN_BLOCK :
              ila_pkg::DWORD * ((req + ila_pkg::DWORD + ila_pkg::DWORD - 1) / ila_pkg::DWORD);
      bp = scan_first(asize);
      if (bp == 0) begin
        e = (asize > grow_min) ? asize : {15'd0, grow_min};
        words = e / ila_pkg::WORD;
        if (words[0]) words = words + 1;
        bp = raise_break(words * ila_pkg::WORD);
      end
      if (bp == 0) r.status = ila_pkg::ST_FULL;
      else begin
        place(bp, asize);
        r.addr = bp;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    alloc_result_t exp_r, got;
    if (rst) begin
      for (int i = 0; i < NWORDS; i++) tags[i] = 32'd0;
      grow_min = ila_pkg::EXTEND_RESET;
      tag_wr(ila_pkg::WORD, ila_pkg::DWORD | ila_pkg::ALLOC_BIT);
      tag_wr(ila_pkg::DWORD, ila_pkg::DWORD | ila_pkg::ALLOC_BIT);
      tag_wr(ila_pkg::WORD + ila_pkg::DWORD, ila_pkg::ALLOC_BIT);
      brk = 16;
      void'(raise_break(ila_pkg::FIRST_CHUNK));
      results_due.delete();
      fails = 0;
    end else begin
      if (cfg_we) grow_min = cfg_wdata;
      if (m_tvalid && m_tready) begin
        got = '{addr: m_tdata[15:0], status: m_tdata[17:16]};
        if (results_due.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("unexpected result addr=%0d status=%0d", got.addr, got.status);
        end else begin
          exp_r = results_due.pop_front();
          if (got !== exp_r || m_tdata[23:18] !== 6'd0) begin
            fails++;
            if (fails <= 10)
              $display("mismatch: expected addr=%0d status=%0d, got addr=%0d status=%0d",
                       exp_r.addr, exp_r.status, got.addr, got.status);
          end
        end
      end
      if (s_tvalid && s_tready)
        results_due.push_back(predict(s_tuser, s_tdata[15:0], s_tdata[31:16]));
    end
    pending <= results_due.size();
  end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Stimulus and verdict for implicit_list_allocator: allocate/free streams under backpressure.
// Depends on ila_pkg, implicit_list_allocator and ila_scoreboard.
module testbench;

  localparam int WATCHDOG = 200000;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic                      s_tuser = 1'b0;
  logic [31:0]               s_tdata = '0;
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic [23:0]               m_tdata;
  logic                      cfg_we = 1'b0;
  logic [ila_pkg::EXT_W-1:0] cfg_wdata = '0;
  int                        fail_cnt;
  int                        pend;
  int                        idle_cycles = 0;
  int                        stall_left = 0;
  bit                        calm = 1'b0;
  bit                        sent_ops [$];
  logic [15:0]               live_blocks [$];

  implicit_list_allocator dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  ila_scoreboard chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .fails(fail_cnt), .pending(pend)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (sent_ops.size() != 0 && sent_ops.pop_front() == 1'b0 &&
          m_tdata[17:16] == ila_pkg::ST_OK)
        live_blocks.push_back(m_tdata[15:0]);
    end
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("** implicit_list_allocator: FAILED **");
      $finish;
    end
  end

  always @(negedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (calm || r < 70) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= 1'b0;
      stall_left <= (r < 96) ? $urandom_range(0, 3) : $urandom_range(20, 60);
    end
  end

  task automatic send(bit op, logic [15:0] req, logic [15:0] ba);
    int gap;
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tuser  = op;
    s_tdata  = {ba, req};
    #1;
    while (!s_tready) begin
      @(negedge clk);
      #1;
    end
    @(posedge clk);
    sent_ops.push_back(op);
    gap = calm ? 0 : (($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(10, 50));
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pend != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic set_growth(logic [ila_pkg::EXT_W-1:0] v);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic free_at(int idx);
    logic [15:0] a;
    a = live_blocks[idx];
    live_blocks.delete(idx);
    send(1'b1, 16'($urandom), a);
  endtask

  task automatic random_item(bit wild);
    int r;
    logic [15:0] sz;
    r = $urandom_range(0, 99);
    if (wild && r < 4) begin
      send(1'b1, 16'($urandom), 16'($urandom));
    end else if (r < 42 && live_blocks.size() != 0) begin
      free_at($urandom_range(0, live_blocks.size() - 1));
    end else begin
      r = $urandom_range(0, 99);
      if (r < 3) sz = 16'd0;
      else if (r < 70) sz = 16'($urandom_range(1, 64));
      else if (r < 95) sz = 16'($urandom_range(65, 1024));
      else sz = 16'($urandom);
      send(1'b0, sz, 16'($urandom));
    end
  endtask

  initial begin
    logic [ila_pkg::EXT_W-1:0] growth [5];
    growth = '{17'd8, 17'd65536, ila_pkg::EXTEND_RESET, 17'd24, 17'($urandom_range(8, 65536))};
    repeat (8) @(negedge clk);
    rst = 1'b0;

    set_growth(growth[0]);
    send(1'b0, 16'd0, 16'hFFFF);
    send(1'b0, 16'd1, 16'd0);
    send(1'b0, 16'd8, 16'd0);
    send(1'b0, 16'd9, 16'd0);
    send(1'b0, 16'hFFFF, 16'd0);
    send(1'b0, 16'd4000, 16'd0);
    send(1'b0, 16'd100, 16'd0);
    send(1'b0, 16'd100, 16'd0);
    send(1'b0, 16'd100, 16'd0);
    send(1'b0, 16'd24, 16'd0);
    drain();
    // the third free finds both neighbors free
    free_at(live_blocks.size() - 4);
    free_at(live_blocks.size() - 2);
    free_at(live_blocks.size() - 2);
    free_at(live_blocks.size() - 1);
    free_at(0);
    send(1'b0, 16'd40, 16'd0);
    send(1'b0, 16'd5000, 16'd0);
    drain();

    for (int p = 0; p < 5; p++) begin
      if (p != 0) set_growth(growth[p]);
      calm = (p == 2);
      repeat (260) random_item(p == 4);
      drain();
    end

    if (fail_cnt == 0 && pend == 0) begin
      $display("** implicit_list_allocator: PASSED **");
    end else begin
      $display("** implicit_list_allocator: FAILED **");
    end
    $finish;
  end

endmodule
